### rtl/pwm_timer_counter_8bit_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 8-bit timer/counter
// Shared property templates for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef PWM_TIMER_COUNTER_8BIT_CORE_MACROS_SVH
`define PWM_TIMER_COUNTER_8BIT_CORE_MACROS_SVH

`define PTC8_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define PTC8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ptc8_pkg.sv
// ----------------------------------------------------------------------------
// Timer/counter package
// Payload types, operation and register codes, waveform decode helpers.
// ----------------------------------------------------------------------------
package ptc8_pkg;

   typedef struct packed {
      logic [2:0] action;
      logic       edge_rising;
      logic [2:0] reg_select;
      logic [7:0] write_data;
      logic       clock_gated;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       flag_compare_a;
      logic       flag_compare_b;
      logic       flag_overflow;
      logic       level_out_a;
      logic       level_out_b;
      logic       drive_a;
      logic       drive_b;
      logic [4:0] warnings;
   } rsp_type;

   typedef enum logic [2:0] {
      PIN_HOLD,
      PIN_TOGGLE,
      PIN_CLEAR,
      PIN_SET,
      PIN_RESERVED
   } pin_action_type;

   typedef enum logic [2:0] {
      CLS_NORMAL,
      CLS_PC,
      CLS_CTC,
      CLS_FAST,
      CLS_RESERVED
   } wave_class_type;

   typedef enum logic [1:0] {
      BUF_NONE,
      BUF_AT_MAX,
      BUF_AT_BOTTOM
   } buf_mode_type;

   localparam logic [2:0] OP_TICK           = 3'd0;
   localparam logic [2:0] OP_EXT_EDGE       = 3'd1;
   localparam logic [2:0] OP_WRITE          = 3'd2;
   localparam logic [2:0] OP_READ           = 3'd3;
   localparam logic [2:0] OP_PRESCALE_RESET = 3'd4;

   localparam logic [2:0] SEL_CTRL_A = 3'd0;
   localparam logic [2:0] SEL_CTRL_B = 3'd1;
   localparam logic [2:0] SEL_COUNT  = 3'd2;
   localparam logic [2:0] SEL_CMP_A  = 3'd3;
   localparam logic [2:0] SEL_CMP_B  = 3'd4;

   localparam logic [2:0] CS_STOP     = 3'd0;
   localparam logic [2:0] CS_DIV1     = 3'd1;
   localparam logic [2:0] CS_DIV8     = 3'd2;
   localparam logic [2:0] CS_DIV64    = 3'd3;
   localparam logic [2:0] CS_DIV256   = 3'd4;
   localparam logic [2:0] CS_DIV1024  = 3'd5;
   localparam logic [2:0] CS_EXT_FALL = 3'd6;
   localparam logic [2:0] CS_EXT_RISE = 3'd7;

   localparam logic [2:0] WGM_PC_FF   = 3'd1;
   localparam logic [2:0] WGM_CTC     = 3'd2;
   localparam logic [2:0] WGM_PC_OCRA = 3'd5;
   localparam logic [2:0] WGM_FAST_OCRA = 3'd7;

   localparam logic [7:0] CTRL_A_MASK = 8'hF3;
   localparam logic [7:0] COUNT_MAX   = 8'hFF;

   function automatic wave_class_type class_of(logic [2:0] wgm);
      wave_class_type cls;
      case (wgm)
         3'd0:       cls = CLS_NORMAL;
         3'd1, 3'd5: cls = CLS_PC;
         3'd2:       cls = CLS_CTC;
         3'd3, 3'd7: cls = CLS_FAST;
         default:    cls = CLS_RESERVED;
      endcase
      return cls;
   endfunction

   function automatic buf_mode_type buf_mode(wave_class_type cls);
      buf_mode_type bm;
      case (cls)
         CLS_PC:   bm = BUF_AT_MAX;
         CLS_FAST: bm = BUF_AT_BOTTOM;
         default:  bm = BUF_NONE;
      endcase
      return bm;
   endfunction

   function automatic pin_action_type channel_action(logic [7:0] ctrl_a, logic [3:0] ctrl_b,
                                                     logic ch_b, logic at_top);
      wave_class_type cls;
      logic [1:0]     com;
      pin_action_type act;
      pin_action_type top_act;
      cls     = class_of({ctrl_b[3], ctrl_a[1:0]});
      com     = ch_b ? ctrl_a[5:4] : ctrl_a[7:6];
      top_act = PIN_HOLD;
      case (com)
         2'd1:    act = PIN_TOGGLE;
         2'd2:    act = PIN_CLEAR;
         2'd3:    act = PIN_SET;
         default: act = PIN_HOLD;
      endcase
      if (cls == CLS_FAST || cls == CLS_PC) begin
         if (act == PIN_TOGGLE) begin
            if (ch_b) begin
               act = PIN_RESERVED;
            end else if (!ctrl_b[3]) begin
               act = PIN_HOLD;
            end
         end else if (cls == CLS_FAST && act == PIN_CLEAR) begin
            top_act = PIN_SET;
         end else if (cls == CLS_FAST && act == PIN_SET) begin
            top_act = PIN_CLEAR;
         end
      end
      return at_top ? top_act : act;
   endfunction

   function automatic logic pin_apply(logic level, pin_action_type act, logic up);
      logic res;
      case (act)
         PIN_TOGGLE: res = !level;
         PIN_SET:    res = up;
         PIN_CLEAR:  res = !up;
         default:    res = level;
      endcase
      return res;
   endfunction

   function automatic logic [9:0] prescale_mask(logic [2:0] cs);
      logic [9:0] m;
      case (cs)
         CS_DIV8:    m = 10'd7;
         CS_DIV64:   m = 10'd63;
         CS_DIV256:  m = 10'd255;
         CS_DIV1024: m = 10'd1023;
         default:    m = 10'd0;
      endcase
      return m;
   endfunction

   function automatic logic [1:0] source_of(logic [2:0] cs);
      logic [1:0] src;
      case (cs)
         CS_STOP:     src = 2'd0;
         CS_EXT_FALL: src = 2'd2;
         CS_EXT_RISE: src = 2'd3;
         default:     src = 2'd1;
      endcase
      return src;
   endfunction

endpackage

### rtl/pwm_timer_counter_8bit_core.sv
// ----------------------------------------------------------------------------
// 8-bit PWM timer/counter core
// Response valid is registered and rises in the cycle after a request transfer.
// Throughput: one item per cycle while rsp_ready is not held low, set by the single registered update pass.
// Reset clears control, counter, compare and pin state; direction is up.
// ----------------------------------------------------------------------------
`include "pwm_timer_counter_8bit_core_macros.svh"

module pwm_timer_counter_8bit_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptc8_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptc8_pkg::rsp_type rsp_data
);

   logic [7:0] ctrl_a_ff, ctrl_a_in;
   logic [3:0] ctrl_b_ff, ctrl_b_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] act_a_ff, act_a_in;
   logic [7:0] act_b_ff, act_b_in;
   logic [7:0] pend_a_ff, pend_a_in;
   logic [7:0] pend_b_ff, pend_b_in;
   logic       up_ff, up_in;
   logic [9:0] presc_ff, presc_in;
   logic [1:0] pins_ff, pins_in;
   logic       rsp_valid_ff, rsp_valid_in;
   ptc8_pkg::rsp_type rsp_ff, rsp_in;

   logic                     req_fire;
   logic [2:0]               wgm_old;
   logic [2:0]               cs_old;
   ptc8_pkg::wave_class_type cls_old;
   ptc8_pkg::wave_class_type cls_new;
   ptc8_pkg::buf_mode_type   bm_old;
   logic                     count_event;
   logic [7:0]               ovf_val;
   logic [7:0]               top_val;
   logic                     pa, pb;
   logic                     flag_a, flag_b, flag_ovf;
   logic [7:0]               rd;
   logic [4:0]               warn;
   ptc8_pkg::pin_action_type drv_a_act, drv_b_act;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign wgm_old = {ctrl_b_ff[3], ctrl_a_ff[1:0]};
   assign cs_old  = ctrl_b_ff[2:0];
   assign cls_old = ptc8_pkg::class_of(wgm_old);
   assign bm_old  = ptc8_pkg::buf_mode(cls_old);

   always_comb begin
      ctrl_a_in   = ctrl_a_ff;
      ctrl_b_in   = ctrl_b_ff;
      count_in    = count_ff;
      act_a_in    = act_a_ff;
      act_b_in    = act_b_ff;
      pend_a_in   = pend_a_ff;
      pend_b_in   = pend_b_ff;
      up_in       = up_ff;
      pa          = pins_ff[0];
      pb          = pins_ff[1];
      rd          = 8'd0;
      warn        = 5'd0;
      flag_a      = 1'b0;
      flag_b      = 1'b0;
      flag_ovf    = 1'b0;
      count_event = 1'b0;
      cls_new     = cls_old;
      ovf_val     = ptc8_pkg::COUNT_MAX;
      top_val     = ptc8_pkg::COUNT_MAX;
      presc_in    = req_data.clock_gated ? 10'd0 : presc_ff;

      case (req_data.action)
         ptc8_pkg::OP_TICK: begin
            if (!req_data.clock_gated) begin
               presc_in = presc_ff + 10'd1;
               if (cs_old inside {[ptc8_pkg::CS_DIV1:ptc8_pkg::CS_DIV1024]} &&
                   (presc_in & ptc8_pkg::prescale_mask(cs_old)) == 10'd0) begin
                  count_event = 1'b1;
               end
            end
         end
         ptc8_pkg::OP_EXT_EDGE: begin
            count_event = (cs_old == ptc8_pkg::CS_EXT_FALL && !req_data.edge_rising) ||
                          (cs_old == ptc8_pkg::CS_EXT_RISE && req_data.edge_rising);
         end
         ptc8_pkg::OP_WRITE: begin
            case (req_data.reg_select)
               ptc8_pkg::SEL_CTRL_A: begin
                  ctrl_a_in = req_data.write_data & ptc8_pkg::CTRL_A_MASK;
                  cls_new   = ptc8_pkg::class_of({ctrl_b_ff[3], ctrl_a_in[1:0]});
                  if (cls_new != cls_old) begin
                     up_in   = 1'b1;
                     warn[4] = (cs_old != ptc8_pkg::CS_STOP);
                     warn[0] = (cls_new == ptc8_pkg::CLS_RESERVED);
                  end
                  warn[1] = (ptc8_pkg::channel_action(ctrl_a_in, ctrl_b_ff, 1'b1, 1'b0) ==
                             ptc8_pkg::PIN_RESERVED);
               end
               ptc8_pkg::SEL_CTRL_B: begin
                  ctrl_b_in = req_data.write_data[3:0];
                  cls_new   = ptc8_pkg::class_of({ctrl_b_in[3], ctrl_a_ff[1:0]});
                  if (cls_new != cls_old) begin
                     up_in   = 1'b1;
                     warn[4] = (cs_old != ptc8_pkg::CS_STOP);
                     warn[0] = (cls_new == ptc8_pkg::CLS_RESERVED);
                  end
                  warn[1] = (ptc8_pkg::channel_action(ctrl_a_ff, ctrl_b_in, 1'b1, 1'b0) ==
                             ptc8_pkg::PIN_RESERVED);
                  warn[3] = (ptc8_pkg::source_of(ctrl_b_in[2:0]) !=
                             ptc8_pkg::source_of(cs_old)) &&
                            (cs_old != ptc8_pkg::CS_STOP) &&
                            (ctrl_b_in[2:0] != ptc8_pkg::CS_STOP);
                  if (cls_new inside {ptc8_pkg::CLS_NORMAL, ptc8_pkg::CLS_CTC}) begin
                     if (req_data.write_data[7]) begin
                        pa = ptc8_pkg::pin_apply(pa,
                           ptc8_pkg::channel_action(ctrl_a_ff, ctrl_b_in, 1'b0, 1'b0), up_in);
                     end
                     if (req_data.write_data[6]) begin
                        pb = ptc8_pkg::pin_apply(pb,
                           ptc8_pkg::channel_action(ctrl_a_ff, ctrl_b_in, 1'b1, 1'b0), up_in);
                     end
                  end
               end
               ptc8_pkg::SEL_COUNT: begin
                  count_in = req_data.write_data;
                  warn[2]  = (cs_old != ptc8_pkg::CS_STOP);
               end
               ptc8_pkg::SEL_CMP_A: begin
                  pend_a_in = req_data.write_data;
                  if (bm_old == ptc8_pkg::BUF_NONE) begin
                     act_a_in = req_data.write_data;
                  end
               end
               ptc8_pkg::SEL_CMP_B: begin
                  pend_b_in = req_data.write_data;
                  if (bm_old == ptc8_pkg::BUF_NONE) begin
                     act_b_in = req_data.write_data;
                  end
               end
               default: begin
               end
            endcase
         end
         ptc8_pkg::OP_READ: begin
            case (req_data.reg_select)
               ptc8_pkg::SEL_CTRL_A: rd = ctrl_a_ff;
               ptc8_pkg::SEL_CTRL_B: rd = {4'd0, ctrl_b_ff};
               ptc8_pkg::SEL_COUNT:  rd = count_ff;
               ptc8_pkg::SEL_CMP_A:  rd = (bm_old != ptc8_pkg::BUF_NONE) ? pend_a_ff : act_a_ff;
               ptc8_pkg::SEL_CMP_B:  rd = (bm_old != ptc8_pkg::BUF_NONE) ? pend_b_ff : act_b_ff;
               default:              rd = 8'd0;
            endcase
         end
         ptc8_pkg::OP_PRESCALE_RESET: begin
            presc_in = 10'd0;
         end
         default: begin
         end
      endcase

      if (count_event) begin
         if (wgm_old inside {ptc8_pkg::WGM_PC_FF, ptc8_pkg::WGM_PC_OCRA}) begin
            ovf_val = 8'd0;
         end else if (wgm_old == ptc8_pkg::WGM_FAST_OCRA) begin
            ovf_val = act_a_ff;
         end
         if (count_ff == act_a_ff) begin
            pa = ptc8_pkg::pin_apply(pa,
               ptc8_pkg::channel_action(ctrl_a_ff, ctrl_b_ff, 1'b0, 1'b0), up_ff);
            flag_a = 1'b1;
         end
         if (count_ff == act_b_ff) begin
            pb = ptc8_pkg::pin_apply(pb,
               ptc8_pkg::channel_action(ctrl_a_ff, ctrl_b_ff, 1'b1, 1'b0), up_ff);
            flag_b = 1'b1;
         end
         flag_ovf = (count_ff == ovf_val);
         if ((bm_old == ptc8_pkg::BUF_AT_MAX && count_ff == ptc8_pkg::COUNT_MAX) ||
             (bm_old == ptc8_pkg::BUF_AT_BOTTOM && count_ff == 8'd0)) begin
            act_a_in = pend_a_ff;
            act_b_in = pend_b_ff;
         end
         if (wgm_old inside {ptc8_pkg::WGM_CTC, ptc8_pkg::WGM_PC_OCRA,
                             ptc8_pkg::WGM_FAST_OCRA}) begin
            top_val = act_a_in;
         end
         if (up_ff) begin
            if (count_ff == top_val) begin
               pa = ptc8_pkg::pin_apply(pa,
                  ptc8_pkg::channel_action(ctrl_a_ff, ctrl_b_ff, 1'b0, 1'b1), up_ff);
               pb = ptc8_pkg::pin_apply(pb,
                  ptc8_pkg::channel_action(ctrl_a_ff, ctrl_b_ff, 1'b1, 1'b1), up_ff);
               count_in = 8'd0;
               if (cls_old == ptc8_pkg::CLS_PC) begin
                  up_in    = 1'b0;
                  count_in = (top_val == 8'd0) ? 8'd0 : top_val - 8'd1;
               end
            end else begin
               count_in = count_ff + 8'd1;
            end
         end else if (count_ff == 8'd0) begin
            up_in    = 1'b1;
            count_in = 8'd1;
         end else begin
            count_in = count_ff - 8'd1;
         end
      end

      pins_in   = {pb, pa};
      drv_a_act = ptc8_pkg::channel_action(ctrl_a_in, ctrl_b_in, 1'b0, 1'b0);
      drv_b_act = ptc8_pkg::channel_action(ctrl_a_in, ctrl_b_in, 1'b1, 1'b0);

      rsp_in.read_data      = rd;
      rsp_in.flag_compare_a = flag_a;
      rsp_in.flag_compare_b = flag_b;
      rsp_in.flag_overflow  = flag_ovf;
      rsp_in.level_out_a    = pa;
      rsp_in.level_out_b    = pb;
      rsp_in.drive_a        = (drv_a_act != ptc8_pkg::PIN_HOLD);
      rsp_in.drive_b        = (drv_b_act != ptc8_pkg::PIN_HOLD) &&
                              (drv_b_act != ptc8_pkg::PIN_RESERVED);
      rsp_in.warnings       = warn;

      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff    <= 8'd0;
         ctrl_b_ff    <= 4'd0;
         count_ff     <= 8'd0;
         act_a_ff     <= 8'd0;
         act_b_ff     <= 8'd0;
         pend_a_ff    <= 8'd0;
         pend_b_ff    <= 8'd0;
         up_ff        <= 1'b1;
         presc_ff     <= 10'd0;
         pins_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            ctrl_a_ff <= ctrl_a_in;
            ctrl_b_ff <= ctrl_b_in;
            count_ff  <= count_in;
            act_a_ff  <= act_a_in;
            act_b_ff  <= act_b_in;
            pend_a_ff <= pend_a_in;
            pend_b_ff <= pend_b_in;
            up_ff     <= up_in;
            presc_ff  <= presc_in;
            pins_ff   <= pins_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   `PTC8_ASSERT_SAME(a_down_only_pc, clock, reset,
      !up_ff, cls_old == ptc8_pkg::CLS_PC,
      "Counting down outside phase-correct mode.")
   `PTC8_ASSERT_NEXT(a_gated_presc_clear, clock, reset,
      req_fire && req_data.clock_gated, presc_ff == 10'd0,
      "Prescaler not cleared by a gated item.")
   `PTC8_ASSERT_NEXT(a_fire_gives_rsp, clock, reset,
      req_fire, rsp_valid_ff,
      "Accepted item produced no response.")

endmodule

### tb/ptc8_response_check.sv
// ----------------------------------------------------------------------------
// Response checker for the 8-bit PWM timer/counter
// Watches both channels, keeps its own copy of the timer state, predicts
// the response of every accepted request transfer and compares each
// accepted response transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ptc8_response_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ptc8_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ptc8_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                open_count,
   output int                checked_count,
   output int                flag_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ptc8_pkg::*;

   localparam logic [2:0] WGM_NORMAL  = 3'd0;
   localparam logic [2:0] WGM_FAST_FF = 3'd3;

   localparam int WARN_RESERVED_MODE = 0;
   localparam int WARN_RESERVED_B    = 1;
   localparam int WARN_COUNT_WRITE   = 2;
   localparam int WARN_CLOCK_SWITCH  = 3;
   localparam int WARN_MODE_CHANGE   = 4;

   logic [7:0]     ctrl_a;
   logic [3:0]     ctrl_b;
   logic [7:0]     cnt;
   logic [7:0]     ocr_a;
   logic [7:0]     ocr_b;
   logic [7:0]     ocr_a_buf;
   logic [7:0]     ocr_b_buf;
   logic           up;
   wave_class_type cls_state;
   logic [9:0]     presc;
   logic [1:0]     pins;

   rsp_type due_results[$];

   function automatic logic [2:0] wgm();
      return {ctrl_b[3], ctrl_a[1:0]};
   endfunction

   function automatic wave_class_type decode_class(logic [2:0] w);
      case (w)
         WGM_NORMAL:               return CLS_NORMAL;
         WGM_PC_FF, WGM_PC_OCRA:   return CLS_PC;
         WGM_CTC:                  return CLS_CTC;
         WGM_FAST_FF, WGM_FAST_OCRA: return CLS_FAST;
         default:                  return CLS_RESERVED;
      endcase
   endfunction

   function automatic logic [7:0] top_of();
      logic [2:0] w;
      w = wgm();
      return (w == WGM_CTC || w == WGM_PC_OCRA || w == WGM_FAST_OCRA) ? ocr_a : COUNT_MAX;
   endfunction

   function automatic logic [7:0] ovf_of();
      logic [2:0] w;
      w = wgm();
      if (w == WGM_PC_FF || w == WGM_PC_OCRA) return 8'h00;
      if (w == WGM_FAST_OCRA) return ocr_a;
      return COUNT_MAX;
   endfunction

   function automatic buf_mode_type buffering();
      wave_class_type c;
      c = decode_class(wgm());
      if (c == CLS_PC) return BUF_AT_MAX;
      if (c == CLS_FAST) return BUF_AT_BOTTOM;
      return BUF_NONE;
   endfunction

   // The compare output bits map one to one onto the pin action codes.
   function automatic pin_action_type match_action(logic ch_b, logic at_top);
      wave_class_type c;
      logic [1:0]     com;
      pin_action_type act;
      pin_action_type top_act;
      c       = decode_class(wgm());
      com     = ch_b ? ctrl_a[5:4] : ctrl_a[7:6];
      act     = pin_action_type'({1'b0, com});
      top_act = PIN_HOLD;
      if (c == CLS_FAST || c == CLS_PC) begin
         if (act == PIN_TOGGLE) begin
            if (ch_b) begin
               act = PIN_RESERVED;
            end else if (!ctrl_b[3]) begin
               act = PIN_HOLD;
            end
         end else if (c == CLS_FAST && act == PIN_CLEAR) begin
            top_act = PIN_SET;
         end else if (c == CLS_FAST && act == PIN_SET) begin
            top_act = PIN_CLEAR;
         end
      end
      return at_top ? top_act : act;
   endfunction

   function automatic void drive_pin(logic ch_b, pin_action_type act);
      case (act)
         PIN_TOGGLE: pins[ch_b] = ~pins[ch_b];
         PIN_SET:    pins[ch_b] = up;
         PIN_CLEAR:  pins[ch_b] = ~up;
         default: ;
      endcase
   endfunction

   function automatic logic [2:0] count_step();
      logic [2:0]   flags;
      logic [7:0]   top;
      buf_mode_type bm;
      flags = 3'b000;
      if (cnt == ocr_a) begin
         drive_pin(1'b0, match_action(1'b0, 1'b0));
         flags[0] = 1'b1;
      end
      if (cnt == ocr_b) begin
         drive_pin(1'b1, match_action(1'b1, 1'b0));
         flags[1] = 1'b1;
      end
      if (cnt == ovf_of()) flags[2] = 1'b1;
      bm = buffering();
      if ((bm == BUF_AT_MAX && cnt == COUNT_MAX) || (bm == BUF_AT_BOTTOM && cnt == 8'h00)) begin
         ocr_a = ocr_a_buf;
         ocr_b = ocr_b_buf;
      end
      if (up) begin
         top = top_of();
         if (cnt == top) begin
            drive_pin(1'b0, match_action(1'b0, 1'b1));
            drive_pin(1'b1, match_action(1'b1, 1'b1));
            cnt = 8'h00;
            if (cls_state == CLS_PC) begin
               up  = 1'b0;
               cnt = (top != 8'h00) ? top - 8'd1 : 8'h00;
            end
         end else begin
            cnt = cnt + 8'd1;
         end
      end else if (cnt == 8'h00) begin
         up  = 1'b1;
         cnt = 8'h01;
      end else begin
         cnt = cnt - 8'd1;
      end
      return flags;
   endfunction

   function automatic logic [4:0] refresh_wave(logic [2:0] old_cs);
      wave_class_type c;
      logic [4:0]     w;
      w = 5'b00000;
      c = decode_class(wgm());
      if (c != cls_state) begin
         cls_state = c;
         up        = 1'b1;
         if (old_cs != CS_STOP) w[WARN_MODE_CHANGE] = 1'b1;
         if (c == CLS_RESERVED) w[WARN_RESERVED_MODE] = 1'b1;
      end
      if (match_action(1'b1, 1'b0) == PIN_RESERVED) w[WARN_RESERVED_B] = 1'b1;
      return w;
   endfunction

   function automatic logic [1:0] timebase_of(logic [2:0] cs);
      if (cs == CS_STOP) return 2'd0;
      if (cs == CS_EXT_FALL) return 2'd2;
      if (cs == CS_EXT_RISE) return 2'd3;
      return 2'd1;
   endfunction

   function automatic int tick_divisor(logic [2:0] cs);
      case (cs)
         CS_DIV1:    return 1;
         CS_DIV8:    return 8;
         CS_DIV64:   return 64;
         CS_DIV256:  return 256;
         CS_DIV1024: return 1024;
         default:    return 0;
      endcase
   endfunction

   function automatic rsp_type predict_timer_step(req_type r);
      rsp_type        res;
      logic [2:0]     cs;
      logic [2:0]     old_cs;
      logic [2:0]     flags;
      logic [4:0]     w;
      logic [7:0]     rd;
      int             div;
      pin_action_type act_b;
      flags = 3'b000;
      w     = 5'b00000;
      rd    = 8'h00;
      cs    = ctrl_b[2:0];
      if (r.clock_gated) presc = 10'd0;
      case (r.action)
         OP_TICK: begin
            if (!r.clock_gated) begin
               presc = presc + 10'd1;
               div   = tick_divisor(cs);
               if (div != 0 && (presc % div) == 0) flags = count_step();
            end
         end
         OP_EXT_EDGE: begin
            if ((cs == CS_EXT_FALL && !r.edge_rising) || (cs == CS_EXT_RISE && r.edge_rising))
               flags = count_step();
         end
         OP_WRITE: begin
            case (r.reg_select)
               SEL_CTRL_A: begin
                  ctrl_a = r.write_data & CTRL_A_MASK;
                  w      = w | refresh_wave(cs);
               end
               SEL_CTRL_B: begin
                  old_cs = cs;
                  ctrl_b = r.write_data[3:0];
                  w      = w | refresh_wave(old_cs);
                  if (timebase_of(ctrl_b[2:0]) != timebase_of(old_cs) &&
                      old_cs != CS_STOP && ctrl_b[2:0] != CS_STOP)
                     w[WARN_CLOCK_SWITCH] = 1'b1;
                  if (cls_state == CLS_NORMAL || cls_state == CLS_CTC) begin
                     if (r.write_data[7]) drive_pin(1'b0, match_action(1'b0, 1'b0));
                     if (r.write_data[6]) drive_pin(1'b1, match_action(1'b1, 1'b0));
                  end
               end
               SEL_COUNT: begin
                  cnt = r.write_data;
                  if (cs != CS_STOP) w[WARN_COUNT_WRITE] = 1'b1;
               end
               SEL_CMP_A: begin
                  ocr_a_buf = r.write_data;
                  if (buffering() == BUF_NONE) ocr_a = r.write_data;
               end
               SEL_CMP_B: begin
                  ocr_b_buf = r.write_data;
                  if (buffering() == BUF_NONE) ocr_b = r.write_data;
               end
               default: ;
            endcase
         end
         OP_READ: begin
            case (r.reg_select)
               SEL_CTRL_A: rd = ctrl_a;
               SEL_CTRL_B: rd = {4'h0, ctrl_b};
               SEL_COUNT:  rd = cnt;
               SEL_CMP_A:  rd = (buffering() != BUF_NONE) ? ocr_a_buf : ocr_a;
               SEL_CMP_B:  rd = (buffering() != BUF_NONE) ? ocr_b_buf : ocr_b;
               default:    rd = 8'h00;
            endcase
         end
         OP_PRESCALE_RESET: presc = 10'd0;
         default: ;
      endcase
      act_b              = match_action(1'b1, 1'b0);
      res.read_data      = rd;
      res.flag_compare_a = flags[0];
      res.flag_compare_b = flags[1];
      res.flag_overflow  = flags[2];
      res.level_out_a    = pins[0];
      res.level_out_b    = pins[1];
      res.drive_a        = (match_action(1'b0, 1'b0) != PIN_HOLD);
      res.drive_b        = (act_b != PIN_HOLD && act_b != PIN_RESERVED);
      res.warnings       = w;
      return res;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         ctrl_a    = 8'h00;
         ctrl_b    = 4'h0;
         cnt       = 8'h00;
         ocr_a     = 8'h00;
         ocr_b     = 8'h00;
         ocr_a_buf = 8'h00;
         ocr_b_buf = 8'h00;
         up        = 1'b1;
         cls_state = CLS_NORMAL;
         presc     = 10'd0;
         pins      = 2'b00;
         due_results.delete();
      end else begin
         if (req_valid && req_ready) due_results.push_back(predict_timer_step(req_data));
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               fail_count++;
               $display("%0t ns: response transfer with nothing expected, actual %h",
                        $time, rsp_data);
            end else begin
               want = due_results.pop_front();
               checked_count++;
               if (want.flag_compare_a || want.flag_compare_b || want.flag_overflow)
                  flag_count++;
               check_field("read_data", want.read_data, rsp_data.read_data);
               check_field("flag_compare_a", 8'(want.flag_compare_a),
                           8'(rsp_data.flag_compare_a));
               check_field("flag_compare_b", 8'(want.flag_compare_b),
                           8'(rsp_data.flag_compare_b));
               check_field("flag_overflow", 8'(want.flag_overflow),
                           8'(rsp_data.flag_overflow));
               check_field("level_out_a", 8'(want.level_out_a), 8'(rsp_data.level_out_a));
               check_field("level_out_b", 8'(want.level_out_b), 8'(rsp_data.level_out_b));
               check_field("drive_a", 8'(want.drive_a), 8'(rsp_data.drive_a));
               check_field("drive_b", 8'(want.drive_b), 8'(rsp_data.drive_b));
               check_field("warnings", 8'(want.warnings), 8'(rsp_data.warnings));
            end
         end
      end
      open_count = due_results.size();
   end

endmodule

### tb/tb_pwm_timer_counter_8bit_core.sv
// ----------------------------------------------------------------------------
// Testbench for the 8-bit PWM timer/counter core
// Sends a short directed sequence and then random mode setups, each followed
// by a burst of ticks, edges and bus accesses, with random idle cycles on
// both channels and one long response hold-off; the checker gives the count.
// ----------------------------------------------------------------------------
module tb_pwm_timer_counter_8bit_core;
   timeunit 1ns;
   timeprecision 1ps;
   import ptc8_pkg::*;

   localparam int ITEM_TARGET  = 1800;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_START   = 600;
   localparam int HOLD_CYCLES  = 250;
   localparam int QUIET_START  = 1500;
   localparam int QUIET_END    = 2000;

   localparam logic [2:0] WGM_RESERVED = 3'd4;
   localparam logic [2:0] SEL_UNUSED   = 3'd7;
   localparam logic [2:0] OP_UNUSED    = 3'd7;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int mismatches;
   int open_results;
   int checked_results;
   int flagged_events;
   int items_sent;
   int rx_cycles;
   int run_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pwm_timer_counter_8bit_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ptc8_response_check i_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (mismatches),
      .open_count    (open_results),
      .checked_count (checked_results),
      .flag_count    (flagged_events)
   );

   always @(posedge clock) begin
      run_cycles++;
      if (run_cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", run_cycles);
         $display("[pwm_timer_counter_8bit_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
         end else if (rx_cycles >= QUIET_START && rx_cycles < QUIET_END) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 28);
         end
      end
   end

   function automatic logic [7:0] ctrl_a_byte(pin_action_type act_a, pin_action_type act_b,
                                              logic [2:0] wgm);
      return {2'(act_a), 2'(act_b), 2'b00, wgm[1:0]};
   endfunction

   function automatic logic [7:0] ctrl_b_byte(logic force_a, logic force_b, logic [2:0] wgm,
                                              logic [2:0] cs);
      return {force_a, force_b, 2'b00, wgm[2], cs};
   endfunction

   task automatic send(input logic [2:0] op, input logic rising, input logic [2:0] sel,
                       input logic [7:0] data, input logic gated);
      req_type item;
      logic    steady;
      item.action      = op;
      item.edge_rising = rising;
      item.reg_select  = sel;
      item.write_data  = data;
      item.clock_gated = gated;
      steady = (rx_cycles >= QUIET_START && rx_cycles < QUIET_END);
      if (!steady && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 28);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (op <= OP_PRESCALE_RESET) items_sent++;
   endtask

   task automatic send_random_access();
      int         pick;
      logic [2:0] sel;
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
         send(OP_TICK, 1'($urandom), 3'($urandom), 8'($urandom),
              ($urandom_range(0, 99) < 4));
      end else if (pick < 78) begin
         send(OP_EXT_EDGE, 1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 86) begin
         send(OP_READ, 1'($urandom), 3'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 93) begin
         sel = ($urandom_range(0, 1) == 1) ? 3'($urandom_range(SEL_CMP_A, SEL_CMP_B))
                                           : 3'($urandom);
         send(OP_WRITE, 1'($urandom), sel, 8'($urandom), 1'b0);
      end else if (pick < 96) begin
         send(OP_PRESCALE_RESET, 1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
      end else begin
         send(3'($urandom_range(OP_PRESCALE_RESET + 1, OP_UNUSED)), 1'($urandom),
              3'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   function automatic logic [7:0] random_compare();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return 8'($urandom_range(0, 15));
      if (pick < 30) return 8'h00;
      if (pick < 35) return COUNT_MAX;
      return 8'($urandom);
   endfunction

   function automatic logic [2:0] random_source();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return CS_DIV1;
      if (pick < 55) return CS_DIV8;
      if (pick < 60) return CS_DIV64;
      if (pick < 62) return CS_DIV256;
      if (pick < 63) return CS_DIV1024;
      if (pick < 78) return CS_EXT_FALL;
      if (pick < 93) return CS_EXT_RISE;
      return CS_STOP;
   endfunction

   initial begin
      logic [2:0] wgm;
      logic [7:0] data;
      int         burst;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send(OP_READ, 1'b0, SEL_CTRL_A, 8'h00, 1'b0);
      send(OP_WRITE, 1'b0, SEL_CMP_A, 8'hFF, 1'b0);
      send(OP_WRITE, 1'b1, SEL_CMP_B, 8'h00, 1'b0);
      send(OP_WRITE, 1'b0, SEL_CTRL_A, ctrl_a_byte(PIN_TOGGLE, PIN_SET, WGM_CTC), 1'b0);
      send(OP_WRITE, 1'b0, SEL_CTRL_B, ctrl_b_byte(1'b1, 1'b1, WGM_CTC, CS_DIV1), 1'b0);
      send(OP_TICK, 1'b0, SEL_CTRL_A, 8'h00, 1'b0);
      send(OP_WRITE, 1'b0, SEL_COUNT, 8'hFF, 1'b0);
      send(OP_TICK, 1'b0, SEL_CTRL_A, 8'h00, 1'b0);
      send(OP_TICK, 1'b0, SEL_CTRL_A, 8'h00, 1'b0);
      send(OP_WRITE, 1'b0, SEL_CTRL_B, ctrl_b_byte(1'b0, 1'b0, WGM_CTC, CS_EXT_FALL), 1'b0);
      send(OP_EXT_EDGE, 1'b0, SEL_CTRL_A, 8'h00, 1'b1);
      send(OP_EXT_EDGE, 1'b1, SEL_CTRL_A, 8'h00, 1'b0);
      send(OP_WRITE, 1'b0, SEL_CTRL_A, ctrl_a_byte(PIN_CLEAR, PIN_TOGGLE, WGM_FAST_OCRA), 1'b0);
      send(OP_WRITE, 1'b0, SEL_CTRL_B, ctrl_b_byte(1'b1, 1'b1, WGM_FAST_OCRA, CS_STOP), 1'b0);
      send(OP_WRITE, 1'b0, SEL_CTRL_A, ctrl_a_byte(PIN_HOLD, PIN_HOLD, WGM_RESERVED), 1'b0);
      send(OP_WRITE, 1'b0, SEL_CMP_A, 8'h00, 1'b0);
      send(OP_WRITE, 1'b0, SEL_CTRL_A, ctrl_a_byte(PIN_TOGGLE, PIN_CLEAR, WGM_PC_OCRA), 1'b0);
      send(OP_WRITE, 1'b0, SEL_CTRL_B, ctrl_b_byte(1'b0, 1'b0, WGM_PC_OCRA, CS_DIV1), 1'b0);
      send(OP_TICK, 1'b0, SEL_CTRL_A, 8'h00, 1'b0);
      send(OP_TICK, 1'b0, SEL_CTRL_A, 8'h00, 1'b0);
      send(OP_TICK, 1'b0, SEL_CTRL_A, 8'h00, 1'b0);
      send(OP_READ, 1'b0, SEL_CMP_A, 8'h00, 1'b0);
      send(OP_PRESCALE_RESET, 1'b0, SEL_CTRL_A, 8'h00, 1'b0);
      send(OP_TICK, 1'b0, SEL_CTRL_A, 8'h00, 1'b1);
      send(OP_WRITE, 1'b0, SEL_UNUSED, 8'hAA, 1'b0);
      send(OP_READ, 1'b0, SEL_UNUSED, 8'h00, 1'b0);
      send(OP_UNUSED, 1'b1, SEL_CMP_B, 8'h55, 1'b0);

      // Each round sets up a mode, a clock source and both compare values, then
      // lets the counter run with bus traffic and noise mixed in.
      while (items_sent < ITEM_TARGET) begin
         wgm  = 3'($urandom);
         data = 8'($urandom);
         data[1:0] = wgm[1:0];
         send(OP_WRITE, 1'($urandom), SEL_CTRL_A, data, 1'b0);
         data = 8'($urandom);
         data[3:0] = {wgm[2], random_source()};
         send(OP_WRITE, 1'($urandom), SEL_CTRL_B, data, 1'b0);
         send(OP_WRITE, 1'($urandom), SEL_CMP_A, random_compare(), 1'b0);
         send(OP_WRITE, 1'($urandom), SEL_CMP_B, random_compare(), 1'b0);
         if ($urandom_range(0, 1) == 1)
            send(OP_WRITE, 1'($urandom), SEL_COUNT, 8'($urandom), 1'b0);
         burst = $urandom_range(20, 250);
         repeat (burst) send_random_access();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Covered %0d request transfers and %0d checked responses, %0d with flags set.",
               items_sent, checked_results, flagged_events);
      if (mismatches == 0) begin
         $display("[pwm_timer_counter_8bit_core] OK");
      end else begin
         $display("%0d mismatches.", mismatches);
         $display("[pwm_timer_counter_8bit_core] ERROR");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/ptc8_pkg.sv
rtl/pwm_timer_counter_8bit_core.sv
tb/ptc8_response_check.sv
tb/tb_pwm_timer_counter_8bit_core.sv
